// ----- rtl/pmf_pkg.sv -----
// Shared constants and types for the pattern masking filter.
// No dependencies; pmf_core, pmf_burst and the top level import this package.
`timescale 1ns / 1ps

package pmf_pkg;

    localparam int CFG_W = 64;   // widest configuration register
    localparam int IDX_W = 2;    // configuration register index
    localparam int CNT_W = 5;    // byte counts, 0 to 16

    localparam logic [IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // Load request from the window stage into the output burst buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } t_burst_ctl;

endpackage

// ----- rtl/pmf_in_if.sv -----
// Input channel of the pattern masking filter: valid/ready plus one stream item.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// ----- rtl/pmf_out_if.sv -----
// Output channel of the pattern masking filter: valid/ready plus one result byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- rtl/pmf_core.sv -----
// Input register, configuration registers, pending byte window and match logic.
// Depends on pmf_pkg and pmf_in_if; feeds the burst buffer in pmf_burst.
`timescale 1ns / 1ps

module pmf_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pmf_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [pmf_pkg::CFG_W-1:0]  i_cfg_data,
    pmf_in_if.sink                     i_in,
    input  logic                       i_burst_free,
    output pmf_pkg::t_burst_ctl        o_ctl,
    output logic [7:0]                 o_bytes [MAX_PATTERN]
);
    import pmf_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PATTERN);

    logic [CFG_W-1:0]   r_pat_low;
    logic [CFG_W-1:0]   r_pat_high;
    logic [CNT_W-1:0]   r_len;

    logic               r_in_valid;
    logic               r_in_kind;
    logic [7:0]         r_in_byte;

    logic [7:0]         r_win [MAX_PATTERN];
    logic [CNT_W-1:0]   r_count;

    logic [7:0]         n_win [MAX_PATTERN];
    logic [CNT_W-1:0]   n_count;
    logic [7:0]         w_ins [MAX_PATTERN];
    logic [7:0]         w_pat [MAX_PATTERN];
    logic [2*CFG_W-1:0] w_pat_all;
    logic [CNT_W-1:0]   w_len;
    logic               w_full;
    logic               w_match;
    logic               w_proc;

    assign w_proc     = r_in_valid && i_burst_free;
    assign i_in.ready = i_rst_n && (!r_in_valid || w_proc);
    assign w_pat_all  = {r_pat_high, r_pat_low};

    // Clamp the programmed length into 1..MAX_PATTERN
    always_comb begin
        w_len = r_len;
        if (r_len == '0) begin
            w_len = CNT_W'(1);
        end else if (r_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end
    end

    assign w_full = (r_count == w_len - CNT_W'(1));

    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_pat[i] = w_pat_all[8*i +: 8];
            w_ins[i] = (CNT_W'(i) == r_count) ? r_in_byte : r_win[i];
            if ((CNT_W'(i) < w_len) && (w_ins[i] != w_pat[i])) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_win       = r_win;
        n_count     = r_count;
        o_ctl.load  = 1'b0;
        o_ctl.count = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_bytes[i] = r_win[i];
        end
        if (w_proc) begin
            if (r_in_kind) begin
                // end of stream: flush pending bytes as they are
                o_ctl.load  = (r_count != '0);
                o_ctl.count = r_count;
                n_count     = '0;
            end else if (!w_full) begin
                n_win   = w_ins;
                n_count = r_count + CNT_W'(1);
            end else if (w_match) begin
                o_ctl.load  = 1'b1;
                o_ctl.count = w_len;
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    o_bytes[i] = STAR_BYTE;
                end
                n_count = '0;
            end else begin
                // emit the oldest byte and drop it from the window
                o_ctl.load  = 1'b1;
                o_ctl.count = CNT_W'(1);
                o_bytes[0]  = w_ins[0];
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    n_win[i] = w_ins[i+1];
                end
                n_win[MAX_PATTERN-1] = w_ins[MAX_PATTERN-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                REG_PATTERN_LENGTH: r_len      <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            // a new length discards the pending bytes
            if (i_cfg_we && (i_cfg_index == REG_PATTERN_LENGTH)) begin
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_byte <= i_in.data_byte;
        end
        r_win <= n_win;
    end

endmodule

// ----- rtl/pmf_burst.sv -----
// Output burst buffer: holds the results of one item and sends them one per transfer.
// Depends on pmf_pkg and pmf_out_if; loaded by pmf_core.
`timescale 1ns / 1ps

module pmf_burst #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pmf_pkg::t_burst_ctl i_ctl,
    input  logic [7:0]          i_bytes [MAX_PATTERN],
    output logic                o_free,
    pmf_out_if.source           o_out
);
    import pmf_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_bytes [MAX_PATTERN];
    logic             w_xfer;

    assign w_xfer         = o_out.valid && o_out.ready;
    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_bytes[0];
    assign o_out.run_last = (r_cnt == CNT_W'(1));
    // free once empty or while the last result is taken
    assign o_free         = (r_cnt == '0) || (o_out.run_last && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= i_ctl.count;
        end else if (w_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bytes <= i_bytes;
        end else if (w_xfer) begin
            // advance the next result to the head
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

endmodule

// ----- rtl/pattern_masking_filter_top.sv -----
// Pattern masking filter: copies a byte stream and replaces each pattern hit by asterisks.
// Top level: instantiates pmf_core and pmf_burst; uses pmf_pkg, pmf_in_if, pmf_out_if.
//
// Usage:
//   i_in carries items: kind 0 is a stream byte, kind 1 ends the stream and flushes the
//   pending bytes unmasked. o_out carries result bytes; run_last marks the final result
//   of the item that caused them. Items that cause no result produce no transfer.
//   The pattern (two 64-bit words, first byte in the low bits) and its length are
//   written through the i_cfg_* port while the block is idle; a length write empties
//   the window of pending bytes.
//   The first result of an item passes through the input register and then the burst
//   buffer before it appears on o_out.
//   Throughput: one item per cycle while each item yields at most one result and the
//   receiver is ready. An item yielding n results (a masked hit or a flush) holds the
//   burst buffer for n output transfers; the input register keeps the next item meanwhile.
//   Reset (synchronous, active low) empties the window and the buffer, sets the
//   pattern to zero with length one, and holds i_in.ready low.
//   When the receiver stalls, the current result holds and one further item waits in
//   the input register before i_in.ready drops.
`timescale 1ns / 1ps

module pattern_masking_filter_top #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pmf_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pmf_pkg::CFG_W-1:0] i_cfg_data,
    pmf_in_if.sink                    i_in,
    pmf_out_if.source                 o_out
);
    import pmf_pkg::*;

    t_burst_ctl w_ctl;
    logic [7:0] w_bytes [MAX_PATTERN];
    logic       w_free;

    pmf_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .i_burst_free (w_free),
        .o_ctl        (w_ctl),
        .o_bytes      (w_bytes)
    );

    pmf_burst #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_bytes (w_bytes),
        .o_free  (w_free),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/pmf_checker.sv -----
// Port-level checks for the pattern masking filter, bound to the top level.
// Depends on pattern_masking_filter_top's ports only.
`timescale 1ns / 1ps

module pmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a burst continues until its last result is taken
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("result burst broke off before its last transfer");

    // reset empties the output buffer and blocks input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_no_accept_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_in_ready)
        else $error("input ready while in reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind pattern_masking_filter_top pmf_checker u_pmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.run_last)
);
